[rtl/lzwc_pkg.sv]
// lzwc_pkg: shared constants, state codes and control structs for the LZW compressor.
// No dependencies.
`timescale 1ns / 1ps

package lzwc_pkg;

   // Default configuration of the code space and string table
   localparam int CODE_BITS_DEF     = 14;
   localparam int TABLE_ENTRIES_DEF = 18041;
   localparam int FULL_WAIT_DEF     = 1000;

   // Table generation tag carried in every stored entry
   localparam int EPOCH_W = 6;

   // Output byte counter
   localparam int COUNT_W = 24;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PROBE = 5'b00010,
      ST_EMIT  = 5'b00100,
      ST_WAIT  = 5'b01000,
      ST_CLEAR = 5'b10000
   } lzwc_state_type;

   // Stream phase
   typedef enum logic [2:0] {
      PH_IDLE    = 3'b001,
      PH_ACTIVE  = 3'b010,
      PH_ABORTED = 3'b100
   } lzwc_phase_type;

   // Sequencer to packer
   typedef struct packed {
      logic clear;       // new stream: drop pending bits, zero the count
      logic step_start;  // new request: forget the previous overflow
   } lzwc_pk_ctrl_type;

   // Packer to sequencer
   typedef struct packed {
      logic idle;        // fewer than eight bits pending
      logic ovf;         // this request hit the size limit
   } lzwc_pk_stat_type;

endpackage

[rtl/lzwc_table.sv]
// lzwc_table: string table memory, one write port and one registered read port.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module lzwc_table #(
   parameter int WORD_W  = 42,
   parameter int ENTRIES = 18041,
   parameter int IDX_W   = 15
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lzwc_packer.sv]
// lzwc_packer: packs codes MSB first into bytes, counts bytes, checks the size limit
// and holds the response register. Depends on lzwc_pkg.
`timescale 1ns / 1ps

module lzwc_packer #(
   parameter int CODE_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lzwc_pkg::lzwc_pk_ctrl_type      ctrl,
   output lzwc_pkg::lzwc_pk_stat_type      stat,
   input  logic                            code_valid,
   input  logic [CODE_BITS-1:0]            code,
   input  logic                            code_last,
   input  logic                            code_end,
   output logic                            code_ready,
   input  logic [lzwc_pkg::COUNT_W-1:0]    max_bytes,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_in_run,
   output logic                            rsp_stream_end,
   output logic                            rsp_overflow,
   output logic [lzwc_pkg::COUNT_W-1:0]    rsp_byte_count
);
   import lzwc_pkg::*;

   localparam int BW = CODE_BITS + 7;
   localparam int CW = $clog2(CODE_BITS + 8);

   logic [BW-1:0]      bits_ff, bits_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               drop_ff, drop_in;
   logic               last_ff, last_in;
   logic               end_ff, end_in;
   logic               ov_ff, ov_in;
   logic [7:0]         ob_ff, ob_in;
   logic               ol_ff, ol_in;
   logic               oe_ff, oe_in;
   logic               oo_ff, oo_in;
   logic [COUNT_W-1:0] oc_ff, oc_in;

   logic               have_byte;
   logic               byte_go;
   logic [BW-1:0]      shifted;
   logic [CW-1:0]      rest;
   logic               is_last;
   logic               is_ovf;

   assign have_byte  = (count_ff >= CW'(8));
   assign code_ready = !have_byte;
   assign byte_go    = have_byte && !drop_ff && (!ov_ff || !rsp_stall);
   assign rest       = count_ff - CW'(8);
   assign shifted    = bits_ff >> rest;
   assign is_last    = last_ff && (rest < CW'(8));
   assign is_ovf     = (cnt_ff >= max_bytes);

   assign stat.idle  = !have_byte;
   assign stat.ovf   = drop_ff;

   // Packing, byte extraction and response register
   always_comb begin
      bits_in  = bits_ff;
      count_in = count_ff;
      cnt_in   = cnt_ff;
      drop_in  = drop_ff;
      last_in  = last_ff;
      end_in   = end_ff;
      ov_in    = ov_ff;
      ob_in    = ob_ff;
      ol_in    = ol_ff;
      oe_in    = oe_ff;
      oo_in    = oo_ff;
      oc_in    = oc_ff;

      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end

      if (code_valid && code_ready && !drop_ff) begin
         bits_in  = {bits_ff[BW-1-CODE_BITS:0], code};
         count_in = count_ff + CW'(CODE_BITS);
         last_in  = code_last;
         end_in   = code_end;
      end

      if (byte_go) begin
         cnt_in   = (cnt_ff == COUNT_MAX) ? cnt_ff : cnt_ff + COUNT_W'(1);
         count_in = rest;
         ov_in    = 1'b1;
         ob_in    = shifted[7:0];
         ol_in    = is_last || is_ovf;
         oe_in    = is_last && end_ff && !is_ovf;
         oo_in    = is_ovf;
         oc_in    = cnt_in;
         if (is_ovf) begin
            drop_in  = 1'b1;
            count_in = '0;
         end else if (is_last && end_ff) begin
            // leftover bits at stream end are dropped
            count_in = '0;
         end
      end

      if (ctrl.step_start) begin
         drop_in = 1'b0;
      end
      if (ctrl.clear) begin
         count_in = '0;
         cnt_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         last_ff  <= 1'b0;
         end_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         cnt_ff   <= cnt_in;
         drop_ff  <= drop_in;
         last_ff  <= last_in;
         end_ff   <= end_in;
         ov_ff    <= ov_in;
      end
      bits_ff <= bits_in;
      ob_ff   <= ob_in;
      ol_ff   <= ol_in;
      oe_ff   <= oe_in;
      oo_ff   <= oo_in;
      oc_ff   <= oc_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_out_byte    = ob_ff;
   assign rsp_last_in_run = ol_ff;
   assign rsp_stream_end  = oe_ff;
   assign rsp_overflow    = oo_ff;
   assign rsp_byte_count  = oc_ff;

endmodule

[rtl/lzw_compressor_14bit_unit.sv]
// LZW compressor, 14-bit codes: a request is taken in IDLE alone when the stream is
// aborted, and passes PROBE (more probes past occupied slots) on a hit without final
// flag; the first byte of a stream and requests whose codes go out pass EMIT and WAIT,
// held longer where the byte-serial packer (one byte a cycle) or a stalled response
// holds a code. Reset is synchronous; afterwards a clearing pass over all TABLE_ENTRIES
// entries runs, and again on every 63rd table clear when the generation tag wraps.
`timescale 1ns / 1ps

module lzw_compressor_14bit_unit #(
   parameter int CODE_BITS     = lzwc_pkg::CODE_BITS_DEF,
   parameter int TABLE_ENTRIES = lzwc_pkg::TABLE_ENTRIES_DEF,
   parameter int FULL_WAIT     = lzwc_pkg::FULL_WAIT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_final_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_byte,
   output logic                         rsp_last_in_run,
   output logic                         rsp_stream_end,
   output logic                         rsp_overflow,
   output logic [lzwc_pkg::COUNT_W-1:0] rsp_byte_count,
   input  logic                         csr_wr_en,
   input  logic [lzwc_pkg::COUNT_W-1:0] csr_wr_data
);
   import lzwc_pkg::*;

   localparam int IDX_W  = $clog2(TABLE_ENTRIES);
   localparam int TRY_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int NF_W   = $clog2((1 << CODE_BITS) + FULL_WAIT + 2);
   localparam int WORD_W = EPOCH_W + 2 * CODE_BITS + 8;
   localparam int SW     = IDX_W + 2;
   localparam logic [CODE_BITS-1:0] END_CODE = '1;
   localparam logic [CODE_BITS-1:0] CLR_CODE = END_CODE - CODE_BITS'(1);
   localparam logic [NF_W-1:0] TOP_NF   = NF_W'((1 << CODE_BITS) - 3);
   localparam logic [NF_W-1:0] WAIT_LIM = NF_W'((1 << CODE_BITS) - 3 + FULL_WAIT);
   localparam logic [NF_W-1:0] FIRST_NF = NF_W'(256);

   lzwc_state_type          state_ff, state_in;
   lzwc_phase_type          phase_ff, phase_in;
   logic [CODE_BITS-1:0]    cur_ff, cur_in;
   logic [CODE_BITS-1:0]    old_ff, old_in;
   logic [NF_W-1:0]         nf_ff, nf_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [IDX_W-1:0]        step_ff, step_in;
   logic [TRY_W-1:0]        tries_ff, tries_in;
   logic [IDX_W-1:0]        sweep_ff, sweep_in;
   logic                    sweep_pend_ff, sweep_pend_in;
   logic [EPOCH_W-1:0]      epoch_ff, epoch_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    fin_ff, fin_in;
   logic [4:0]              en_ff, en_in;
   logic [2:0]              seq_ff, seq_in;
   logic [COUNT_W-1:0]      max_ff;

   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [WORD_W-1:0]       wr_data;
   logic [IDX_W-1:0]        rd_addr;
   logic [WORD_W-1:0]       rd_data;

   logic [CODE_BITS-1:0]    hraw;
   logic [SW-1:0]           hv;
   logic [IDX_W-1:0]        hash_idx;
   logic [IDX_W-1:0]        next_idx;

   logic [EPOCH_W-1:0]      ent_tag;
   logic [CODE_BITS-1:0]    ent_code;
   logic [CODE_BITS-1:0]    ent_prefix;
   logic [7:0]              ent_char;
   logic                    ent_used;
   logic                    ent_match;
   logic                    epoch_bump;
   logic [EPOCH_W-1:0]      epoch_inc;

   lzwc_pk_ctrl_type        pk_ctrl;
   lzwc_pk_stat_type        pk_stat;
   logic                    code_valid;
   logic [CODE_BITS-1:0]    code;
   logic                    code_last;
   logic                    code_ready;

   // Size limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= COUNT_MAX;
      end else if (csr_wr_en) begin
         max_ff <= csr_wr_data;
      end
   end

   // Primary hash, reduced modulo the table size
   assign hraw = {req_data_byte, {(CODE_BITS-8){1'b0}}} ^ cur_ff;
   always_comb begin
      hv = SW'(hraw);
      for (int i = 0; i < 3; i++) begin
         if (hv >= SW'(TABLE_ENTRIES)) begin
            hv = hv - SW'(TABLE_ENTRIES);
         end
      end
      hash_idx = hv[IDX_W-1:0];
   end

   // Secondary probe: step back by the stride fixed at the first probe, wrapped
   always_comb begin
      if (idx_ff >= step_ff) begin
         next_idx = idx_ff - step_ff;
      end else begin
         next_idx = IDX_W'({1'b0, idx_ff} + (IDX_W+1)'(TABLE_ENTRIES) - {1'b0, step_ff});
      end
   end

   // Stored entry fields
   assign ent_tag    = rd_data[WORD_W-1 -: EPOCH_W];
   assign ent_code   = rd_data[2*CODE_BITS+7 -: CODE_BITS];
   assign ent_prefix = rd_data[CODE_BITS+7 -: CODE_BITS];
   assign ent_char   = rd_data[7:0];
   assign ent_used   = (ent_tag == epoch_ff);
   assign ent_match  = ent_used && (ent_prefix == cur_ff) && (ent_char == byte_ff);
   assign epoch_inc  = epoch_ff + EPOCH_W'(1);

   assign req_stall = (state_ff != ST_IDLE);

   // Code feed to the packer
   always_comb begin
      case (seq_ff)
         3'd0:    code = old_ff;
         3'd1:    code = CLR_CODE;
         3'd2:    code = cur_ff;
         3'd3:    code = END_CODE;
         default: code = '0;
      endcase
   end
   assign code_valid = (state_ff == ST_EMIT) && en_ff[seq_ff];
   assign code_last  = ((en_ff >> (seq_ff + 3'd1)) == 5'd0);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cur_in        = cur_ff;
      old_in        = old_ff;
      nf_in         = nf_ff;
      idx_in        = idx_ff;
      step_in       = step_ff;
      tries_in      = tries_ff;
      sweep_in      = sweep_ff;
      sweep_pend_in = sweep_pend_ff;
      epoch_in      = epoch_ff;
      byte_in       = byte_ff;
      fin_in        = fin_ff;
      en_in         = en_ff;
      seq_in        = seq_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = {epoch_ff, nf_ff[CODE_BITS-1:0], cur_ff, byte_ff};
      pk_ctrl       = '0;
      epoch_bump    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = '0;
            sweep_in = sweep_ff + IDX_W'(1);
            if (sweep_ff == IDX_W'(TABLE_ENTRIES - 1)) begin
               sweep_in      = '0;
               sweep_pend_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               byte_in            = req_data_byte;
               fin_in             = req_final_byte;
               pk_ctrl.step_start = 1'b1;
               case (phase_ff)
                  PH_ABORTED: begin
                     if (req_final_byte) begin
                        phase_in = PH_IDLE;
                     end
                  end
                  PH_ACTIVE: begin
                     rd_addr  = hash_idx;
                     idx_in   = hash_idx;
                     step_in  = (hash_idx == '0) ? IDX_W'(1) :
                                IDX_W'((IDX_W+1)'(TABLE_ENTRIES) - {1'b0, hash_idx});
                     tries_in = '0;
                     state_in = ST_PROBE;
                  end
                  default: begin
                     // stream start
                     epoch_bump    = 1'b1;
                     nf_in         = FIRST_NF;
                     pk_ctrl.clear = 1'b1;
                     cur_in        = CODE_BITS'(req_data_byte);
                     phase_in      = PH_ACTIVE;
                     en_in         = req_final_byte ? 5'b11100 : 5'b00000;
                     seq_in        = '0;
                     state_in      = ST_EMIT;
                  end
               endcase
            end
         end

         ST_PROBE: begin
            if (ent_match) begin
               cur_in = ent_code;
               en_in  = fin_ff ? 5'b11100 : 5'b00000;
               seq_in = '0;
               state_in = fin_ff ? ST_EMIT : ST_IDLE;
            end else if (ent_used && (tries_ff + TRY_W'(1) != TRY_W'(TABLE_ENTRIES))) begin
               // occupied by another string: next probe
               rd_addr  = next_idx;
               idx_in   = next_idx;
               tries_in = tries_ff + TRY_W'(1);
            end else begin
               // miss; a slot exists only if the entry was free
               old_in = cur_ff;
               cur_in = CODE_BITS'(byte_ff);
               en_in  = {{3{fin_ff}}, 2'b01};
               seq_in = '0;
               state_in = ST_EMIT;
               if (nf_ff <= TOP_NF) begin
                  wr_en = !ent_used;
                  nf_in = nf_ff + NF_W'(1);
               end else if (nf_ff > WAIT_LIM) begin
                  en_in      = {{3{fin_ff}}, 2'b11};
                  epoch_bump = 1'b1;
                  nf_in      = FIRST_NF;
               end else begin
                  nf_in = nf_ff + NF_W'(1);
               end
            end
         end

         ST_EMIT: begin
            if (!en_ff[seq_ff] || code_ready) begin
               seq_in = seq_ff + 3'd1;
               if (seq_ff == 3'd4) begin
                  state_in = ST_WAIT;
               end
            end
         end

         ST_WAIT: begin
            if (pk_stat.idle) begin
               if (pk_stat.ovf) begin
                  phase_in = fin_ff ? PH_IDLE : PH_ABORTED;
               end else if (fin_ff) begin
                  phase_in = PH_IDLE;
               end
               state_in = sweep_pend_ff ? ST_CLEAR : ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // table clear by generation tag; a wrap needs a clearing pass
      if (epoch_bump) begin
         if (epoch_inc == '0) begin
            epoch_in      = EPOCH_W'(1);
            sweep_pend_in = 1'b1;
         end else begin
            epoch_in = epoch_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         phase_ff      <= PH_IDLE;
         cur_ff        <= '0;
         nf_ff         <= FIRST_NF;
         sweep_ff      <= '0;
         sweep_pend_ff <= 1'b1;
         epoch_ff      <= EPOCH_W'(1);
         en_ff         <= '0;
         seq_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         cur_ff        <= cur_in;
         nf_ff         <= nf_in;
         sweep_ff      <= sweep_in;
         sweep_pend_ff <= sweep_pend_in;
         epoch_ff      <= epoch_in;
         en_ff         <= en_in;
         seq_ff        <= seq_in;
      end
      old_ff   <= old_in;
      idx_ff   <= idx_in;
      step_ff  <= step_in;
      tries_ff <= tries_in;
      byte_ff  <= byte_in;
      fin_ff   <= fin_in;
   end

   lzwc_table #(
      .WORD_W  (WORD_W),
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lzwc_packer #(
      .CODE_BITS (CODE_BITS)
   ) u_packer (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (pk_ctrl),
      .stat            (pk_stat),
      .code_valid      (code_valid),
      .code            (code),
      .code_last       (code_last),
      .code_end        (fin_ff),
      .code_ready      (code_ready),
      .max_bytes       (max_ff),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_in_run (rsp_last_in_run),
      .rsp_stream_end  (rsp_stream_end),
      .rsp_overflow    (rsp_overflow),
      .rsp_byte_count  (rsp_byte_count)
   );

endmodule

[rtl/lzwc_checker.sv]
// lzwc_checker: port-level assertions for the LZW compressor, bound to the top level.
// Depends on lzwc_pkg and lzw_compressor_14bit_unit.
`timescale 1ns / 1ps

module lzwc_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [7:0]                   req_data_byte,
   input logic                         req_final_byte,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [7:0]                   rsp_out_byte,
   input logic                         rsp_last_in_run,
   input logic                         rsp_stream_end,
   input logic                         rsp_overflow,
   input logic [lzwc_pkg::COUNT_W-1:0] rsp_byte_count,
   input logic                         csr_wr_en,
   input logic [lzwc_pkg::COUNT_W-1:0] csr_wr_data
);

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_byte_count))
      else $error("stalled response changed");

   // Stream end only on a clean closing byte
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_end |-> rsp_last_in_run && !rsp_overflow)
      else $error("stream end without last flag");

   // Overflow closes the request's run
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_last_in_run)
      else $error("overflow byte not last");

   // Every byte counts itself
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_byte_count != '0)
      else $error("zero byte count on response");

   // Table clearing pass blocks requests after reset
   a_clear: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> req_stall)
      else $error("request taken during clearing pass");

endmodule

bind lzw_compressor_14bit_unit lzwc_checker u_chk (.*);
